>>> hw/rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants of the 3x3 matrix inverse block.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int unsigned IN_W      = 16;
    localparam int unsigned OUT_W     = 32;
    localparam int unsigned NUM_ELEM  = 9;
    localparam int unsigned PROD_W    = 2 * IN_W;       // element product
    localparam int unsigned COF_W     = PROD_W + 1;     // cofactor
    localparam int unsigned DET_W     = 50;             // determinant, signed
    localparam int unsigned DEF_IN_FRAC_BITS  = 8;
    localparam int unsigned DEF_OUT_FRAC_BITS = 16;

    // Cofactor n = m[a] * m[b] - m[c] * m[d], elements indexed row * 3 + col.
    localparam int unsigned COF_IDX [0:8][0:3] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic [NUM_ELEM-1:0][COF_W-1:0] cof;
        logic [DET_W-1:0]               det;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } t_back_state;

endpackage

>>> hw/rtl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front
// Four-stage pipeline forming the adjugate cofactors and the determinant.
// ----------------------------------------------------------------------------
module mi3_front (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [mi3_pkg::NUM_ELEM*mi3_pkg::IN_W-1:0]    i_data,
    output logic                                          o_push,
    input  logic                                          i_full,
    output mi3_pkg::t_job                                 o_job
);

    localparam int unsigned P3_W = mi3_pkg::IN_W + mi3_pkg::COF_W;

    logic                                   w_en;
    logic signed [mi3_pkg::IN_W-1:0]        w_a [0:8];
    logic signed [mi3_pkg::PROD_W-1:0]      r_s1_p [0:17];
    logic signed [mi3_pkg::IN_W-1:0]        r_s1_row [0:2];
    logic signed [mi3_pkg::COF_W-1:0]       r_s2_cof [0:8];
    logic signed [mi3_pkg::IN_W-1:0]        r_s2_row [0:2];
    logic signed [P3_W-1:0]                 r_s3_d [0:2];
    logic signed [mi3_pkg::COF_W-1:0]       r_s3_cof [0:8];
    logic [mi3_pkg::DET_W-1:0]              r_s4_det;
    logic [mi3_pkg::COF_W-1:0]              r_s4_cof [0:8];
    logic                                   r_v1, r_v2, r_v3, r_v4;

    // The whole pipe moves whenever its last stage can leave.
    assign w_en    = !r_v4 || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_v4 && !i_full;

    genvar g;
    generate
        for (g = 0; g < 9; g++) begin : g_elem
            assign w_a[g] = i_data[g*mi3_pkg::IN_W +: mi3_pkg::IN_W];
            assign o_job.cof[g] = r_s4_cof[g];
        end
    endgenerate
    assign o_job.det = r_s4_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int n = 0; n < 9; n++) begin
                r_s1_p[2*n]   <= w_a[mi3_pkg::COF_IDX[n][0]] * w_a[mi3_pkg::COF_IDX[n][1]];
                r_s1_p[2*n+1] <= w_a[mi3_pkg::COF_IDX[n][2]] * w_a[mi3_pkg::COF_IDX[n][3]];
                r_s2_cof[n] <= mi3_pkg::COF_W'(r_s1_p[2*n])
                             - mi3_pkg::COF_W'(r_s1_p[2*n+1]);
                r_s3_cof[n] <= r_s2_cof[n];
                r_s4_cof[n] <= r_s3_cof[n];
            end
            for (int k = 0; k < 3; k++) begin
                r_s1_row[k] <= w_a[k];
                r_s2_row[k] <= r_s1_row[k];
            end
            // Expansion along the first row uses cofactors 00, 10 and 20.
            r_s3_d[0] <= P3_W'(r_s2_row[0]) * P3_W'(r_s2_cof[0]);
            r_s3_d[1] <= P3_W'(r_s2_row[1]) * P3_W'(r_s2_cof[3]);
            r_s3_d[2] <= P3_W'(r_s2_row[2]) * P3_W'(r_s2_cof[6]);
            r_s4_det  <= mi3_pkg::DET_W'(r_s3_d[0]) + mi3_pkg::DET_W'(r_s3_d[1])
                       + mi3_pkg::DET_W'(r_s3_d[2]);
        end
    end

endmodule

>>> hw/rtl/mi3_fifo.sv
// ----------------------------------------------------------------------------
// mi3_fifo
// Two-entry queue of jobs between the front pipeline and the divider back end.
// ----------------------------------------------------------------------------
module mi3_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mi3_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mi3_pkg::t_job o_job
);

    mi3_pkg::t_job r_mem [0:1];
    logic          r_wr, r_rd;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> hw/rtl/mi3_back.sv
// ----------------------------------------------------------------------------
// mi3_back
// Nine bit-serial restoring dividers, saturation and the output register.
// ----------------------------------------------------------------------------
module mi3_back #(
    parameter int unsigned IN_FRAC_BITS  = mi3_pkg::DEF_IN_FRAC_BITS,
    parameter int unsigned OUT_FRAC_BITS = mi3_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_empty,
    input  mi3_pkg::t_job                               i_job,
    output logic                                        o_pop,
    output logic                                        o_tvalid,
    input  logic                                        i_tready,
    output logic [mi3_pkg::NUM_ELEM*mi3_pkg::OUT_W-1:0] o_tdata,
    output logic [1:0]                                  o_tuser
);

    localparam int unsigned SHIFT = IN_FRAC_BITS + OUT_FRAC_BITS;
    localparam int unsigned MAG_W = mi3_pkg::OUT_W;
    localparam int unsigned DIV_W = MAG_W + SHIFT;
    localparam int unsigned REM_W = mi3_pkg::DET_W;
    localparam int unsigned CNT_W = $clog2(DIV_W + 1);
    localparam int unsigned OW    = mi3_pkg::OUT_W;

    mi3_pkg::t_back_state r_state, n_state;

    logic [CNT_W-1:0]  r_cnt;
    logic [REM_W-1:0]  r_den;
    logic              r_det_zero;
    logic [REM_W-1:0]  r_rem [0:8];
    logic [DIV_W-1:0]  r_num [0:8];
    logic [DIV_W-1:0]  r_q   [0:8];
    logic              r_neg [0:8];
    logic [OW-1:0]     w_res [0:8];
    logic [8:0]        w_ovf;
    logic [REM_W-1:0]  w_det_mag;
    logic              w_load, w_run, w_emit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mi3_pkg::BK_IDLE: if (!i_empty) n_state = mi3_pkg::BK_RUN;
            mi3_pkg::BK_RUN:  if (r_cnt == CNT_W'(1)) n_state = mi3_pkg::BK_DONE;
            mi3_pkg::BK_DONE: if (!o_tvalid || i_tready) n_state = mi3_pkg::BK_IDLE;
            default:          n_state = mi3_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        w_load = 1'b0;
        w_run  = 1'b0;
        w_emit = 1'b0;
        unique case (r_state)
            mi3_pkg::BK_IDLE: w_load = !i_empty;
            mi3_pkg::BK_RUN:  w_run  = 1'b1;
            mi3_pkg::BK_DONE: w_emit = !o_tvalid || i_tready;
            default:          w_load = 1'b0;
        endcase
    end

    assign o_pop = w_load;
    assign w_det_mag = i_job.det[REM_W-1] ? (~i_job.det + REM_W'(1)) : i_job.det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mi3_pkg::BK_IDLE;
            o_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                o_tvalid <= 1'b1;
            end else if (i_tready) begin
                o_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cnt      <= CNT_W'(DIV_W);
            r_den      <= w_det_mag;
            r_det_zero <= (i_job.det == '0);
        end else if (w_run) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < 9; g++) begin : g_lane
            logic [mi3_pkg::COF_W-1:0] w_cof;
            logic [mi3_pkg::COF_W-1:0] w_mag;
            logic [REM_W-1:0]          w_rem2;
            logic                      w_ge;
            logic [DIV_W:0]            w_qx;
            logic                      w_big_pos, w_big_neg;

            assign w_cof  = i_job.cof[g];
            assign w_mag  = w_cof[mi3_pkg::COF_W-1] ? (~w_cof + 1'b1) : w_cof;
            assign w_rem2 = {r_rem[g][REM_W-2:0], r_num[g][DIV_W-1]};
            assign w_ge   = (w_rem2 >= r_den);

            always_ff @(posedge i_clk) begin
                if (w_load) begin
                    r_rem[g] <= '0;
                    r_q[g]   <= '0;
                    r_num[g] <= DIV_W'(w_mag[MAG_W-1:0]) << SHIFT;
                    r_neg[g] <= w_cof[mi3_pkg::COF_W-1] ^ i_job.det[REM_W-1];
                end else if (w_run) begin
                    r_rem[g] <= w_ge ? (w_rem2 - r_den) : w_rem2;
                    r_num[g] <= r_num[g] << 1;
                    r_q[g]   <= {r_q[g][DIV_W-2:0], w_ge};
                end
            end

            // Saturate the exact quotient to a signed 32-bit result.
            assign w_qx      = {1'b0, r_q[g]};
            assign w_big_pos = |w_qx[DIV_W:OW-1];
            assign w_big_neg = (|w_qx[DIV_W:OW]) || (w_qx[OW-1] && (|w_qx[OW-2:0]));

            always_comb begin
                w_ovf[g] = 1'b0;
                if (r_det_zero) begin
                    w_res[g] = '0;
                end else if (r_neg[g]) begin
                    w_ovf[g] = w_big_neg;
                    w_res[g] = w_big_neg ? {1'b1, {(OW-1){1'b0}}} : (~r_q[g][OW-1:0] + 1'b1);
                end else begin
                    w_ovf[g] = w_big_pos;
                    w_res[g] = w_big_pos ? {1'b0, {(OW-1){1'b1}}} : r_q[g][OW-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_emit) begin
                    o_tdata[g*OW +: OW] <= w_res[g];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_tuser <= {|w_ovf, r_det_zero};
        end
    end

endmodule

>>> hw/rtl/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a signed fixed-point 3x3 matrix by the adjugate method.
// ----------------------------------------------------------------------------
// A matrix enters as one word and leaves as one word. A four-stage front
// pipeline takes a word in every cycle while its two-entry queue has room,
// forming the nine cofactors and the determinant. The back end divides all
// nine cofactors by the determinant at once in bit-serial dividers, one
// quotient bit per cycle, and finishes one matrix before it takes the next
// from the queue; that divider loop sets the sustained rate. Quotients are
// truncated toward zero and saturated; a zero determinant gives all zeros
// and the singular flag.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
    parameter int unsigned IN_FRAC_BITS  = mi3_pkg::DEF_IN_FRAC_BITS,
    parameter int unsigned OUT_FRAC_BITS = mi3_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input matrix: a00, a01, a02, a10, a11, a12, a20, a21, a22, 16 bits each.
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [143:0]  s_axis_tdata,
    // Output: r00, r01, r02, r10, r11, r12, r20, r21, r22, 32 bits each.
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [287:0]  m_axis_tdata,
    // Flags: singular (bit 0), overflow (bit 1).
    output logic [1:0]    m_axis_tuser
);

    mi3_pkg::t_job w_front_job;
    mi3_pkg::t_job w_fifo_job;
    logic          w_push, w_full, w_pop, w_empty;

    // Cofactors and determinant, one matrix per cycle unless the full queue holds the pipe.
    mi3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_job   (w_front_job)
    );

    // Decouples the pipeline from the long divider loop.
    mi3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_fifo_job)
    );

    // Division, saturation and the output register.
    mi3_back #(
        .IN_FRAC_BITS  (IN_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_job    (w_fifo_job),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

>>> tb/sv/matrix_inverse_3x3_test.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_test
// Self-checking bench for the 3x3 fixed-point matrix inverse block.
// ----------------------------------------------------------------------------
// Matrices go in through a queue-fed driver; every accepted matrix is turned
// into an expected inverse by an independent adjugate and 128-bit division
// predictor. Returned words are compared field by field with the oldest
// expected inverse. Traffic runs in three phases, two with idling both sides.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC_SHIFT = mi3_pkg::DEF_IN_FRAC_BITS
                                       + mi3_pkg::DEF_OUT_FRAC_BITS;
    localparam int unsigned RANDOM_MATRICES = 680;
    localparam longint unsigned CYCLE_LIMIT = 400000;

    typedef logic signed [15:0] t_elem;
    typedef logic signed [31:0] t_inv;

    typedef struct packed {
        t_inv [8:0] r;
        logic       singular;
        logic       overflow;
    } t_inverse;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    // Matrix word: a00, a01, a02, a10, a11, a12, a20, a21, a22 from bit 0 up.
    logic [143:0]   s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    // Inverse word: r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up.
    logic [287:0]   m_axis_tdata;
    // Flags: singular, overflow from bit 0 up.
    logic [1:0]     m_axis_tuser;

    logic [143:0]   pending_matrices[$];
    t_inverse       expected_inverses[$];
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_idle_pct = 0;
    bit             hold_sender = 1'b0;
    bit             in_fire = 1'b0;
    int unsigned    error_count = 0;
    longint unsigned cycle_count = 0;

    matrix_inverse_3x3 DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Exact (cof << FRAC_SHIFT) / det, truncated toward zero, then clamped to
    // 32 bits. The shifted numerator fits in 63 bits, so a 128-bit signed
    // divide is exact and already truncates toward zero.
    function automatic t_inv divide_cofactor(input longint cof, input longint det,
                                             inout logic sat);
        logic signed [127:0] quot;
        begin
            quot = ($signed(128'(cof)) <<< FRAC_SHIFT) / $signed(128'(det));
            if (quot > 128'sd2147483647) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            if (quot < -128'sd2147483648) begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return quot[31:0];
        end
    endfunction

    // Adjugate over determinant for one packed matrix word.
    function automatic t_inverse invert_matrix(input logic [143:0] word);
        longint   m[9];
        longint   adj[9];
        longint   det;
        t_inverse res;
        begin
            for (int k = 0; k < 9; k++) begin
                m[k] = longint'(t_elem'(word[16*k +: 16]));
            end
            adj[0] = m[4] * m[8] - m[5] * m[7];
            adj[1] = m[2] * m[7] - m[1] * m[8];
            adj[2] = m[1] * m[5] - m[2] * m[4];
            adj[3] = m[5] * m[6] - m[3] * m[8];
            adj[4] = m[0] * m[8] - m[2] * m[6];
            adj[5] = m[2] * m[3] - m[0] * m[5];
            adj[6] = m[3] * m[7] - m[4] * m[6];
            adj[7] = m[1] * m[6] - m[0] * m[7];
            adj[8] = m[0] * m[4] - m[1] * m[3];
            det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
            res = '0;
            if (det == 0) begin
                res.singular = 1'b1;
            end else begin
                for (int k = 0; k < 9; k++) begin
                    res.r[k] = divide_cofactor(adj[k], det, res.overflow);
                end
            end
            return res;
        end
    endfunction

    function automatic logic [143:0] pack_matrix(input t_elem e[9]);
        logic [143:0] word;
        begin
            for (int k = 0; k < 9; k++) begin
                word[16*k +: 16] = e[k];
            end
            return word;
        end
    endfunction

    // Random elements: mostly small values that give well-conditioned
    // inverses, with some full-range and edge values mixed in.
    function automatic t_elem random_elem();
        int unsigned pick;
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                return t_elem'($signed($urandom_range(0, 2047)) - 1024);
            end else if (pick < 8) begin
                return t_elem'($urandom);
            end else if (pick == 8) begin
                return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            end
            return t_elem'($signed($urandom_range(0, 4)) - 2);
        end
    endfunction

    // Records whether the input word was taken at this rising edge.
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Driver: presents the next queued matrix at the falling edge. Valid is
    // only dropped once the current word has been taken.
    always @(negedge i_clk) begin
        if (in_fire) begin
            expected_inverses.push_back(invert_matrix(s_axis_tdata));
        end
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (pending_matrices.size() != 0 && !hold_sender
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tdata  <= pending_matrices.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: compares each returned word with the oldest expected inverse.
    always @(posedge i_clk) begin
        t_inverse want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_inverses.size() == 0) begin
                $error("unexpected inverse word %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_inverses.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (m_axis_tdata[32*k +: 32] !== want.r[k]) begin
                        $error("r%0d%0d: expected %0d, got %0d", k / 3, k % 3,
                               want.r[k], $signed(m_axis_tdata[32*k +: 32]));
                        error_count++;
                    end
                end
                if (m_axis_tuser[0] !== want.singular) begin
                    $error("singular: expected %0b, got %0b", want.singular,
                           m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow,
                           m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("matrix_inverse_3x3_test: done, errors");
            $finish;
        end
    end

    initial begin
        t_elem e[9];
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 72;

        // Directed matrices: identity, scaled diagonals, the extremes of every
        // element, singular matrices, tiny determinants of plus and minus one,
        // and a negative result of exactly -2^23, short of saturation.
        e = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};
        pending_matrices.push_back(pack_matrix(e));
        e = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
        pending_matrices.push_back(pack_matrix(e));
        e = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
        pending_matrices.push_back(pack_matrix(e));
        e = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
              16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
        pending_matrices.push_back(pack_matrix(e));
        e = '{1, 2, 3, 2, 4, 6, 16'sh0100, 16'sh0200, 16'sh0300};
        pending_matrices.push_back(pack_matrix(e));
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        pending_matrices.push_back(pack_matrix(e));
        e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        pending_matrices.push_back(pack_matrix(e));
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        pending_matrices.push_back(pack_matrix(e));
        e = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};
        pending_matrices.push_back(pack_matrix(e));
        // Determinant -2^16 at raw scale: r00 is exactly -2^23, no saturation.
        e = '{-2, 0, 0, 0, 16'sh0080, 0, 0, 0, 16'sh0100};
        pending_matrices.push_back(pack_matrix(e));
        e = '{0, 16'sh0100, 0, 0, 0, 16'sh0100, 16'sh0100, 0, 0};
        pending_matrices.push_back(pack_matrix(e));
        e = '{16'sh0300, 16'sh0100, -16'sh0200, 16'sh0100, 16'sh0400,
              16'sh0080, -16'sh0100, 16'sh0200, 16'sh0500};
        pending_matrices.push_back(pack_matrix(e));
        e = '{16'sh5555, 16'shAAAA, 16'sh1234, 16'shFEDC, 16'sh0F0F, 16'shF0F0,
              16'sh00FF, 16'shFF00, 16'sh3C3C};
        pending_matrices.push_back(pack_matrix(e));

        for (int n = 0; n < RANDOM_MATRICES; n++) begin
            for (int k = 0; k < 9; k++) begin
                e[k] = random_elem();
            end
            // Some rows are copied so the random part also hits singular cases.
            if ($urandom_range(0, 15) == 0) begin
                for (int k = 0; k < 3; k++) begin
                    e[6 + k] = e[k];
                end
            end
            pending_matrices.push_back(pack_matrix(e));
            if (n == RANDOM_MATRICES / 3) begin
                wait (pending_matrices.size() == 0);
                // The sender holds off until the block has drained completely.
                hold_sender = 1'b1;
                wait (expected_inverses.size() == 0 && !s_axis_tvalid);
                send_idle_pct = 72;
                recv_idle_pct = 35;
                hold_sender = 1'b0;
            end else if (n == 2 * RANDOM_MATRICES / 3) begin
                wait (pending_matrices.size() == 0);
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end

        wait (pending_matrices.size() == 0 && !s_axis_tvalid);
        wait (expected_inverses.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_inverses.size() == 0) begin
            $display("matrix_inverse_3x3_test: done, clean");
        end else begin
            $display("matrix_inverse_3x3_test: done, errors");
        end
        $finish;
    end

endmodule
